// File: rtl/core/wesm_pkg.sv
package wesm_pkg;

    localparam int PAST_DEPTH   = 64;
    localparam int RECENT_DEPTH = 64;
    localparam int PAW = $clog2(PAST_DEPTH);
    localparam int RAW = $clog2(RECENT_DEPTH);
    localparam int PFW = $clog2(PAST_DEPTH + 1);
    localparam int RFW = $clog2(RECENT_DEPTH + 1);

    localparam logic [2:0] REG_MIN_RULES   = 3'd0;
    localparam logic [2:0] REG_UPDATE_INT  = 3'd1;
    localparam logic [2:0] REG_STOP_INT    = 3'd2;
    localparam logic [2:0] REG_PAST_SIZE   = 3'd3;
    localparam logic [2:0] REG_RECENT_SIZE = 3'd4;
    localparam logic [2:0] REG_MIN_IMPROVE = 3'd5;
    localparam logic [2:0] REG_STOP_POLICY = 3'd6;

    localparam logic [1:0] MODE_MIN  = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;

    localparam logic [1:0] ACT_CONTINUE = 2'd0;
    localparam logic [1:0] ACT_STORE    = 2'd1;
    localparam logic [1:0] ACT_FORCE    = 2'd2;

    typedef struct packed {
        logic           start;
        logic [1:0]     mode;
        logic [PFW-1:0] n;
        logic [PAW-1:0] head;
    } wesm_fold_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } wesm_fold_rsp_t;

endpackage

// File: rtl/core/wesm_divider.sv
module wesm_divider
    import wesm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [37:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [37:0] quotient
);

    logic [37:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [6:0]  d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[37]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd38;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 7'(trial - {1'b0, d_reg});
                q_next = {q_reg[36:0], 1'b1};
            end
            else
            begin
                r_next = trial[6:0];
                q_next = {q_reg[36:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/wesm_fold.sv
module wesm_fold
    import wesm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  wesm_fold_req_t req,
    output logic           rd_en,
    output logic [PAW-1:0] rd_addr,
    input  logic [31:0]    rd_data,
    output wesm_fold_rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]     st_reg, st_next;
    logic [PFW-1:0] issued_reg, issued_next;
    logic [PFW-1:0] got_reg, got_next;
    logic [PAW-1:0] addr_reg, addr_next;
    logic           pend_reg, pend_next;
    logic [37:0]    acc_reg, acc_next;
    logic [1:0]     mode_reg;
    logic [PFW-1:0] n_reg;
    logic           div_start;
    logic           div_done;
    logic [37:0]    div_q;
    logic           done_reg, done_next;
    logic [31:0]    val_reg, val_next;

    always_comb
    begin
        st_next     = st_reg;
        issued_next = issued_reg;
        got_next    = got_reg;
        addr_next   = addr_reg;
        pend_next   = 1'b0;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        val_next    = val_reg;
        div_start   = 1'b0;
        rd_en       = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    st_next     = ST_SCAN;
                    issued_next = '0;
                    got_next    = '0;
                    addr_next   = req.head;
                    acc_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (issued_reg != n_reg)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    issued_next = issued_reg + 1'b1;
                    addr_next   = addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    got_next = got_reg + 1'b1;
                    if (got_reg == '0)
                    begin
                        acc_next = {6'd0, rd_data};
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_MIN:
                            begin
                                if (rd_data < acc_reg[31:0])
                                begin
                                    acc_next = {6'd0, rd_data};
                                end
                            end
                            MODE_MAX:
                            begin
                                if (rd_data > acc_reg[31:0])
                                begin
                                    acc_next = {6'd0, rd_data};
                                end
                            end
                            default:
                            begin
                                acc_next = acc_reg + {6'd0, rd_data};
                            end
                        endcase
                    end
                    if (got_reg + 1'b1 == n_reg)
                    begin
                        if (mode_reg == MODE_MIN || mode_reg == MODE_MAX)
                        begin
                            st_next   = ST_IDLE;
                            done_next = 1'b1;
                            val_next  = acc_next[31:0];
                        end
                        else
                        begin
                            st_next   = ST_DIV;
                            div_start = 1'b1;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    st_next   = ST_IDLE;
                    done_next = 1'b1;
                    val_next  = div_q[31:0];
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issued_reg <= issued_next;
        got_reg    <= got_next;
        addr_reg   <= addr_next;
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        if (st_reg == ST_IDLE && req.start)
        begin
            mode_reg <= req.mode;
            n_reg    <= req.n;
        end
    end

    wesm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_next + 38'(n_reg >> 1)),
        .divisor  (7'(n_reg)),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_addr   = addr_reg;
    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

`ifndef SYNTHESIS
    a_fold_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_SCAN |-> n_reg != '0)
        else $error("fold count zero");
    a_fold_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_SCAN |-> got_reg <= issued_reg)
        else $error("fold read overrun");
    a_fold_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("fold done not a pulse");
`endif

endmodule

// File: rtl/core/windowed_early_stop_monitor.sv
// Each beat runs two serial remainders (rule count modulo the update interval, then
// modulo the stop interval); a stop check then folds the past and the recent window by
// min, max or mean, with a serial divide after each mean fold.
// Throughput: one beat in flight; the next is taken the cycle after the result leaves.
// Reset: asynchronous active-low; config to defaults, windows empty, best infinite, not halted.
module windowed_early_stop_monitor
    import wesm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] rule_count,
    input  logic [31:0] score,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [23:0] best_rule_count
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MOD   = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_FPAST = 4'd3;
    localparam logic [3:0] ST_FREC  = 4'd4;
    localparam logic [3:0] ST_CMP   = 4'd5;
    localparam logic [3:0] ST_RDOLD = 4'd6;
    localparam logic [3:0] ST_PUSH  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_MOD2  = 4'd9;

    logic [23:0] min_rules_reg;
    logic [15:0] upd_reg, stp_reg;
    logic [6:0]  psz_reg, rsz_reg;
    logic [16:0] imp_reg;
    logic [2:0]  pol_reg;

    logic [3:0]     st_reg, st_next;
    logic [23:0]    cnt_reg;
    logic [31:0]    sc_reg;
    logic [RFW-1:0] rfill_reg, rfill_next;
    logic [RAW-1:0] rhead_reg, rhead_next;
    logic [PFW-1:0] pfill_reg, pfill_next;
    logic [PAW-1:0] phead_reg, phead_next;
    logic [31:0]    best_sc_reg, best_sc_next;
    logic [23:0]    best_cnt_reg, best_cnt_next;
    logic           halted_reg, halted_next;
    logic [1:0]     act_reg, act_next;
    logic [23:0]    rep_reg, rep_next;
    logic [31:0]    pa_reg, pa_next;
    logic [23:0]    rem_reg, rem_next;
    logic [15:0]    modi_reg, modi_next;
    logic [4:0]     mbit_reg, mbit_next;
    logic           um_reg, um_next;

    logic [RFW-1:0] ps, rs;
    logic [15:0]    ui, si;
    logic [30:0]    span;
    logic [23:0]    offset;
    logic [16:0]    thr;

    logic [31:0] rmem [RECENT_DEPTH];
    logic [31:0] pmem [PAST_DEPTH];
    logic [31:0] rq, pq;
    logic           r_re, r_we, p_re, p_we;
    logic [RAW-1:0] r_ra, r_wa;
    logic [PAW-1:0] p_ra, p_wa;
    logic [31:0]    r_wd, p_wd;

    wesm_fold_req_t fq;
    wesm_fold_rsp_t fr;
    logic           f_re;
    logic [PAW-1:0] f_addr;
    logic [24:0]    rem_sh;
    logic [RAW:0]   rsum;
    logic [PAW:0]   psum;
    logic signed [50:0] lhs, rhs;

    always_comb
    begin
        ps = (psz_reg == 7'd0) ? RFW'(1) :
             (psz_reg > 7'(PAST_DEPTH)) ? RFW'(PAST_DEPTH) : RFW'(psz_reg);
        rs = (rsz_reg == 7'd0) ? RFW'(1) :
             (rsz_reg > 7'(RECENT_DEPTH)) ? RFW'(RECENT_DEPTH) : RFW'(rsz_reg);
        ui = (upd_reg == 16'd0) ? 16'd1 : upd_reg;
        si = (stp_reg == 16'd0) ? 16'd1 : stp_reg;
        span = 31'((ps + rs)) * 31'(ui);
        offset = (31'(min_rules_reg) > span) ? 24'(31'(min_rules_reg) - span) : 24'd0;
        thr = (imp_reg > 17'd65536) ? 17'd65536 : imp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rules_reg <= 24'd100;
            upd_reg       <= 16'd1;
            stp_reg       <= 16'd1;
            psz_reg       <= 7'd50;
            rsz_reg       <= 7'd50;
            imp_reg       <= 17'd328;
            pol_reg       <= 3'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_RULES:   min_rules_reg <= cfg_data;
                REG_UPDATE_INT:  upd_reg <= cfg_data[15:0];
                REG_STOP_INT:    stp_reg <= cfg_data[15:0];
                REG_PAST_SIZE:   psz_reg <= cfg_data[6:0];
                REG_RECENT_SIZE: rsz_reg <= cfg_data[6:0];
                REG_MIN_IMPROVE: imp_reg <= cfg_data[16:0];
                REG_STOP_POLICY: pol_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // serial remainder: one quotient bit per cycle
    assign rem_sh = {rem_reg, cnt_reg[mbit_reg]};

    always_comb
    begin
        st_next       = st_reg;
        rfill_next    = rfill_reg;
        rhead_next    = rhead_reg;
        pfill_next    = pfill_reg;
        phead_next    = phead_reg;
        best_sc_next  = best_sc_reg;
        best_cnt_next = best_cnt_reg;
        halted_next   = halted_reg;
        act_next      = act_reg;
        rep_next      = rep_reg;
        pa_next       = pa_reg;
        rem_next      = rem_reg;
        modi_next     = modi_reg;
        mbit_next     = mbit_reg;
        um_next       = um_reg;
        fq            = '0;
        r_re = 1'b0; r_we = 1'b0; p_re = 1'b0; p_we = 1'b0;
        r_ra = f_addr[RAW-1:0];
        p_ra = f_addr;
        r_wa = rhead_reg; p_wa = phead_reg;
        r_wd = sc_reg; p_wd = rq;
        rsum = {1'b0, rhead_reg} + (RAW+1)'(rfill_reg);
        psum = {1'b0, phead_reg} + (PAW+1)'(pfill_reg);
        lhs = 51'(signed'({19'd0, pa_reg}) - signed'({19'd0, fr.value})) <<< 16;
        rhs = signed'(51'(thr)) * signed'(51'(fr.value));
        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next   = ST_MOD;
                    act_next  = ACT_CONTINUE;
                    rep_next  = '0;
                    rem_next  = '0;
                    modi_next = ui;
                    mbit_next = 5'd23;
                end
            end
            ST_MOD, ST_MOD2:
            begin
                rem_next = (rem_sh >= {9'd0, modi_reg}) ? 24'(rem_sh - {9'd0, modi_reg})
                                                       : rem_sh[23:0];
                mbit_next = mbit_reg - 5'd1;
                if (mbit_reg == 5'd0)
                begin
                    if (st_reg == ST_MOD)
                    begin
                        um_next   = (rem_next == 24'd0);
                        st_next   = ST_MOD2;
                        rem_next  = '0;
                        modi_next = si;
                        mbit_next = 5'd23;
                    end
                    else
                    begin
                        st_next = ST_DEC;
                    end
                end
            end
            ST_DEC:
            begin
                if (halted_reg || cnt_reg <= offset || !um_reg)
                begin
                    st_next = ST_OUT;
                end
                else
                begin
                    if (pfill_reg >= ps)
                    begin
                        if (sc_reg < best_sc_reg)
                        begin
                            best_sc_next  = sc_reg;
                            best_cnt_next = cnt_reg;
                        end
                    end
                    if (pfill_reg >= ps && rem_reg == 24'd0)
                    begin
                        st_next  = ST_FPAST;
                        fq.start = 1'b1;
                        fq.mode  = pol_reg[2:1];
                        fq.n     = ps;
                        fq.head  = '0;
                    end
                    else
                    begin
                        st_next = ST_RDOLD;
                    end
                end
            end
            ST_FPAST:
            begin
                p_re = f_re;
                if (fr.done)
                begin
                    pa_next  = fr.value;
                    st_next  = ST_FREC;
                    fq.start = 1'b1;
                    fq.mode  = pol_reg[2:1];
                    fq.n     = PFW'(rs);
                    fq.head  = '0;
                end
            end
            ST_FREC:
            begin
                r_re = f_re;
                if (fr.done)
                begin
                    st_next = ST_RDOLD;
                    if (fr.value != 32'd0 && lhs <= rhs)
                    begin
                        act_next    = pol_reg[0] ? ACT_FORCE : ACT_STORE;
                        rep_next    = best_cnt_next;
                        halted_next = 1'b1;
                    end
                end
            end
            ST_RDOLD:
            begin
                r_re    = 1'b1;
                r_ra    = rhead_reg;
                st_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                st_next = ST_OUT;
                r_we    = 1'b1;
                if (rfill_reg < rs)
                begin
                    r_wa = (rsum >= (RAW+1)'(rs)) ? RAW'(rsum - (RAW+1)'(rs)) : RAW'(rsum);
                    rfill_next = rfill_reg + 1'b1;
                end
                else
                begin
                    r_wa       = rhead_reg;
                    rhead_next = (RFW'(rhead_reg) + 1'b1 == rs) ? '0 : rhead_reg + 1'b1;
                    p_we       = 1'b1;
                    if (pfill_reg < ps)
                    begin
                        p_wa = (psum >= (PAW+1)'(ps)) ? PAW'(psum - (PAW+1)'(ps)) : PAW'(psum);
                        pfill_next = pfill_reg + 1'b1;
                    end
                    else
                    begin
                        phead_next = (PFW'(phead_reg) + 1'b1 == ps) ? '0 : phead_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (cfg_we && (cfg_index == REG_PAST_SIZE || cfg_index == REG_RECENT_SIZE))
        begin
            rfill_next = '0; rhead_next = '0; pfill_next = '0; phead_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            rfill_reg    <= '0;
            rhead_reg    <= '0;
            pfill_reg    <= '0;
            phead_reg    <= '0;
            best_sc_reg  <= '1;
            best_cnt_reg <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            rfill_reg    <= rfill_next;
            rhead_reg    <= rhead_next;
            pfill_reg    <= pfill_next;
            phead_reg    <= phead_next;
            best_sc_reg  <= best_sc_next;
            best_cnt_reg <= best_cnt_next;
            halted_reg   <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        rep_reg  <= rep_next;
        pa_reg   <= pa_next;
        rem_reg  <= rem_next;
        modi_reg <= modi_next;
        mbit_reg <= mbit_next;
        um_reg   <= um_next;
        if (st_reg == ST_IDLE && in_valid)
        begin
            cnt_reg <= rule_count;
            sc_reg  <= score;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rmem[r_wa] <= r_wd;
        end
        if (r_re)
        begin
            rq <= rmem[r_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_wa] <= p_wd;
        end
        if (p_re)
        begin
            pq <= pmem[p_ra];
        end
    end

    wesm_fold u_fold (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fq),
        .rd_en   (f_re),
        .rd_addr (f_addr),
        .rd_data ((st_reg == ST_FPAST) ? pq : rq),
        .rsp     (fr)
    );

    assign in_ready        = (st_reg == ST_IDLE);
    assign out_valid       = (st_reg == ST_OUT);
    assign action          = act_reg;
    assign best_rule_count = rep_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rfill_reg <= RFW'(RECENT_DEPTH) && pfill_reg <= PFW'(PAST_DEPTH))
        else $error("window fill beyond depth");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted cleared");
    a_stop_sets_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_CONTINUE |-> halted_reg)
        else $error("stop without halt");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb
    import wesm_pkg::*;
();

    localparam int LIMIT = 3000000;
    localparam int PHASES = 12;

    typedef struct {
        logic [1:0]  act;
        logic [23:0] best;
    } verdict_t;

    typedef struct {
        logic [23:0] count;
        logic [31:0] sc;
        bit          typed;
        logic [1:0]  act;
        logic [23:0] best;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [23:0] rule_count;
    logic [31:0] score;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  action;
    logic [23:0] best_rule_count;

    windowed_early_stop_monitor i_dut (.*);

    // shadow copy of the block
    int unsigned m_min_rules, m_upd, m_stp, m_psize, m_rsize, m_thr, m_policy;
    logic [31:0] past_q [PAST_DEPTH];
    logic [31:0] recent_q [RECENT_DEPTH];
    int unsigned rfill, rhead, pfill, phead;
    logic [31:0] best_sc;
    logic [23:0] best_cnt;
    bit          halted;

    verdict_t verdicts[$];
    int errors = 0;
    int cycles = 0;
    bit calm;
    bit hold_req;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned depth);
        if (v == 0)
            return 1;
        return (v > depth) ? depth : v;
    endfunction

    function automatic logic [31:0] window_agg(input bit past, input int unsigned n,
                                               input int unsigned mode);
        logic [31:0] a;
        logic [31:0] v;
        longint unsigned sum;
        a = past ? past_q[0] : recent_q[0];
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            v = past ? past_q[i] : recent_q[i];
            if (mode == MODE_MIN && v < a)
                a = v;
            if (mode == MODE_MAX && v > a)
                a = v;
            sum += v;
        end
        if (mode != MODE_MIN && mode != MODE_MAX)
            a = 32'((sum + n / 2) / n);
        return a;
    endfunction

    task automatic predict_step(input logic [23:0] count, input logic [31:0] sc,
                                output verdict_t v);
        int unsigned ps, rs, ui, si, span, offset, mode, thr;
        logic [31:0] pa, ra, moved;
        longint lhs, rhs;
        ps = clamp_size(m_psize, PAST_DEPTH);
        rs = clamp_size(m_rsize, RECENT_DEPTH);
        ui = (m_upd == 0) ? 1 : m_upd;
        si = (m_stp == 0) ? 1 : m_stp;
        span = (ps + rs) * ui;
        offset = (m_min_rules > span) ? m_min_rules - span : 0;
        v.act = ACT_CONTINUE;
        v.best = '0;
        if (!halted && count > offset && count % ui == 0)
        begin
            if (pfill >= ps)
            begin
                if (sc < best_sc)
                begin
                    best_sc = sc;
                    best_cnt = count;
                end
                if (count % si == 0)
                begin
                    mode = m_policy >> 1;
                    pa = window_agg(1'b1, ps, mode);
                    ra = window_agg(1'b0, rs, mode);
                    thr = (m_thr > 65536) ? 65536 : m_thr;
                    if (ra != 0)
                    begin
                        lhs = (longint'(pa) - longint'(ra)) * 65536;
                        rhs = longint'(thr) * longint'(ra);
                        if (lhs <= rhs)
                        begin
                            v.act = m_policy[0] ? ACT_FORCE : ACT_STORE;
                            v.best = best_cnt;
                            halted = 1'b1;
                        end
                    end
                end
            end
            if (rfill < rs)
            begin
                recent_q[(rhead + rfill) % rs] = sc;
                rfill++;
            end
            else
            begin
                moved = recent_q[rhead];
                recent_q[rhead] = sc;
                rhead = (rhead + 1) % rs;
                if (pfill < ps)
                begin
                    past_q[(phead + pfill) % ps] = moved;
                    pfill++;
                end
                else
                begin
                    past_q[phead] = moved;
                    phead = (phead + 1) % ps;
                end
            end
        end
    endtask

    // leaves cfg_we high; caller drops it after the last write
    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 24'(val);
        @(posedge clk);
        case (idx)
            REG_MIN_RULES:   m_min_rules = val & 24'hFFFFFF;
            REG_UPDATE_INT:  m_upd = val & 16'hFFFF;
            REG_STOP_INT:    m_stp = val & 16'hFFFF;
            REG_PAST_SIZE:   begin m_psize = val & 7'h7F; rfill = 0; rhead = 0; pfill = 0; phead = 0; end
            REG_RECENT_SIZE: begin m_rsize = val & 7'h7F; rfill = 0; rhead = 0; pfill = 0; phead = 0; end
            REG_MIN_IMPROVE: m_thr = val & 17'h1FFFF;
            REG_STOP_POLICY: m_policy = val & 3'h7;
            default: ;
        endcase
    endtask

    task automatic send(input row_t r);
        verdict_t v;
        in_valid <= 1'b1;
        rule_count <= r.count;
        score <= r.sc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_step(r.count, r.sc, v);
        if (r.typed)
        begin
            v.act = r.act;
            v.best = r.best;
        end
        verdicts.push_back(v);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        verdict_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts.size() == 0)
                report("unexpected beat", action, 0);
            else
            begin
                w = verdicts.pop_front();
                if (action !== w.act)
                    report("action", action, w.act);
                if (best_rule_count !== w.best)
                    report("best_rule_count", best_rule_count, w.best);
            end
        end
    end

    initial begin
        bit held;
        held = 1'b0;
        out_ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        row_t dir [16];
        row_t r;
        int unsigned ui, k0, stepv, base, nitems;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rule_count = '0;
        score = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        m_min_rules = 100; m_upd = 1; m_stp = 1; m_psize = 50; m_rsize = 50;
        m_thr = 328; m_policy = 5;
        rfill = 0; rhead = 0; pfill = 0; phead = 0;
        best_sc = '1; best_cnt = '0; halted = 1'b0;
        foreach (past_q[i]) past_q[i] = '0;
        foreach (recent_q[i]) recent_q[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: windows far from full, every beat continues
        dir[0]  = '{24'd0,        32'd0,          1, ACT_CONTINUE, 24'd0};
        dir[1]  = '{24'hFFFFFF,   32'hFFFFFFFF,   1, ACT_CONTINUE, 24'd0};
        dir[2]  = '{24'h555555,   32'h55555555,   1, ACT_CONTINUE, 24'd0};
        dir[3]  = '{24'hAAAAAA,   32'hAAAAAAAA,   1, ACT_CONTINUE, 24'd0};
        dir[4]  = '{24'd1,        32'd0,          1, ACT_CONTINUE, 24'd0};
        dir[5]  = '{24'd2,        32'hFFFFFFFF,   1, ACT_CONTINUE, 24'd0};
        dir[6]  = '{24'd100,      32'h00010000,   1, ACT_CONTINUE, 24'd0};
        dir[7]  = '{24'd101,      32'h00000001,   1, ACT_CONTINUE, 24'd0};
        dir[8]  = '{24'hFFFFFE,   32'h80000000,   1, ACT_CONTINUE, 24'd0};
        dir[9]  = '{24'h800000,   32'h7FFFFFFF,   1, ACT_CONTINUE, 24'd0};
        dir[10] = '{24'd3,        32'd5,          1, ACT_CONTINUE, 24'd0};
        dir[11] = '{24'd4,        32'd5,          1, ACT_CONTINUE, 24'd0};
        dir[12] = '{24'd5,        32'd0,          1, ACT_CONTINUE, 24'd0};
        dir[13] = '{24'd6,        32'd0,          1, ACT_CONTINUE, 24'd0};
        dir[14] = '{24'h7FFFFF,   32'h0000FFFF,   1, ACT_CONTINUE, 24'd0};
        dir[15] = '{24'd0,        32'hFFFF0000,   1, ACT_CONTINUE, 24'd0};
        foreach (dir[i])
            send(dir[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            cfg_write(REG_MIN_RULES, p == 1 ? 1 : p == 2 ? 24'hFFFFFF : $urandom_range(1, 300));
            ui = (p == 3) ? 0 : (p == 4) ? 65535 : $urandom_range(1, 3);
            cfg_write(REG_UPDATE_INT, ui);
            cfg_write(REG_STOP_INT, (p == 3) ? 0 : (p == 8) ? 65535
                                   : ((ui == 0) ? 1 : ui) * $urandom_range(1, 3));
            cfg_write(REG_PAST_SIZE, (p == 5) ? 0 : (p == 6) ? 64 : $urandom_range(1, 6));
            cfg_write(REG_RECENT_SIZE, (p == 5) ? 127 : (p == 6) ? 64 : $urandom_range(1, 6));
            cfg_write(REG_MIN_IMPROVE, (p < 10) ? 0 : (p == 10) ? 65536 : 131071);
            cfg_write(REG_STOP_POLICY, p % 8);
            cfg_we <= 1'b0;
            @(posedge clk);
            if (p == 7)
                hold_req = 1'b1;

            ui = (m_upd == 0) ? 1 : m_upd;
            k0 = m_min_rules / ui;
            k0 = (k0 > 200) ? k0 - 200 : 0;
            stepv = $urandom_range(1 << 16, 1 << 20);
            base = 32'hF0000000 - $urandom_range(0, 1 << 24);
            nitems = (p == 6) ? 150 : 65;
            for (int j = 0; j < nitems; j++)
            begin
                r.typed = 1'b0;
                r.act = ACT_CONTINUE;
                r.best = '0;
                r.count = 24'(ui * (k0 + 1 + j));
                if ($urandom_range(0, 9) == 0)
                    r.count = 24'($urandom);
                if (p < 10)
                    r.sc = base - j * stepv + $urandom_range(0, stepv / 2);
                else if (p == 10)
                    r.sc = (j < 30) ? 32'd0 : 32'h00020000 + $urandom_range(0, 15);
                else
                    r.sc = $urandom;
                send(r);
            end
            drain();
        end

        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
